@@ rtl/sot_pkg.sv @@
package sot_pkg;

   // token type codes
   localparam logic [3:0] TOK_TEXT       = 4'd0;
   localparam logic [3:0] TOK_LINEBREAK  = 4'd1;
   localparam logic [3:0] TOK_OVR_BEGIN  = 4'd2;
   localparam logic [3:0] TOK_OVR_END    = 4'd3;
   localparam logic [3:0] TOK_TAG_START  = 4'd4;
   localparam logic [3:0] TOK_TAG_NAME   = 4'd5;
   localparam logic [3:0] TOK_OPEN       = 4'd6;
   localparam logic [3:0] TOK_CLOSE      = 4'd7;
   localparam logic [3:0] TOK_ARG_SEP    = 4'd8;
   localparam logic [3:0] TOK_ARG        = 4'd9;
   localparam logic [3:0] TOK_SPACE      = 4'd10;
   localparam logic [3:0] TOK_COMMENT    = 4'd11;
   localparam logic [3:0] TOK_ERROR      = 4'd12;
   localparam logic [3:0] TOK_K_TEMPLATE = 4'd13;
   localparam logic [3:0] TOK_K_VAR      = 4'd14;

   // most tokens delivered for one line
   localparam int TOKEN_CAP = 64;
   localparam int TOK_CNT_W = $clog2(TOKEN_CAP);

   // special characters
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_BANG      = 8'h21;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] token_type;
      logic [6:0] token_length;
      logic       last_token;
      logic       overflow;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic prep0;
      logic prep1;
      logic step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

@@ rtl/sot_control.sv @@
module sot_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   input  sot_pkg::status_type  status,
   output sot_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_PREP0 = 3'd1;
   localparam logic [2:0] ST_PREP1 = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_FINAL = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // input side is open only while collecting a line
   assign req_stall = (state_ff != ST_LOAD);

   // sequencing of load, buffer priming, scan and final token
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_PREP0;
               end
            end
         end
         ST_PREP0: begin
            cmd.prep0 = 1'b1;
            state_in  = ST_PREP1;
         end
         ST_PREP1: begin
            cmd.prep1 = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINAL;
            end else if (status.out_free) begin
               cmd.step = 1'b1;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/sot_datapath.sv @@
module sot_datapath #(
   parameter int MAX_LINE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  sot_pkg::req_payload_type  req_data,
   input  sot_pkg::cmd_type          cmd,
   output sot_pkg::status_type       status,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output sot_pkg::rsp_payload_type  rsp_data
);

   localparam int AW = $clog2(MAX_LINE);
   localparam int CW = $clog2(MAX_LINE + 1);
   localparam int TOK_CNT_W_L = sot_pkg::TOK_CNT_W;

   localparam logic [2:0] MODE_TEXT     = 3'd0;
   localparam logic [2:0] MODE_OVR      = 3'd1;
   localparam logic [2:0] MODE_TAGSTART = 3'd2;
   localparam logic [2:0] MODE_TAGNAME  = 3'd3;
   localparam logic [2:0] MODE_ARG      = 3'd4;

   // multi-byte token in progress
   localparam logic [2:0] CONT_NONE  = 3'd0;
   localparam logic [2:0] CONT_ONE   = 3'd1;
   localparam logic [2:0] CONT_TPL   = 3'd2;
   localparam logic [2:0] CONT_KVAR  = 3'd3;
   localparam logic [2:0] CONT_LOWER = 3'd4;

   function automatic logic is_blank(input logic [7:0] ch);
      return (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
   endfunction

   function automatic logic is_lower(input logic [7:0] ch);
      return (ch >= 8'h61) && (ch <= 8'h7A);
   endfunction

   function automatic logic is_ident(input logic [7:0] ch);
      return is_lower(ch) || (ch >= 8'h41 && ch <= 8'h5A) || (ch == 8'h5F);
   endfunction

   // line buffer
   logic [7:0]    line_mem [MAX_LINE];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [CW:0]   rd_ptr;
   logic          mem_wr;

   // control state
   logic          karaoke_ff, karaoke_in;
   logic [CW-1:0] byte_count_ff, byte_count_in;
   logic [CW-1:0] bang_count_ff, bang_count_in;
   logic [CW-1:0] bang_rem_ff, bang_rem_in;
   logic          overflow_ff, overflow_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [2:0]    mode_ff, mode_in;
   logic [7:0]    paren_ff, paren_in;
   logic [2:0]    cont_ff, cont_in;
   logic          run_valid_ff, run_valid_in;
   logic [TOK_CNT_W_L-1:0] tok_count_ff, tok_count_in;
   logic          hold_valid_ff, hold_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [7:0]    cur_ff, cur_in;
   logic [3:0]    cont_type_ff, cont_type_in;
   logic [3:0]    run_type_ff, run_type_in;
   logic [6:0]    run_len_ff, run_len_in;
   logic [3:0]    hold_type_ff, hold_type_in;
   logic [6:0]    hold_len_ff, hold_len_in;
   sot_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // classification of the current byte
   logic [3:0]    tok_type;
   logic [2:0]    mode_nx;
   logic [7:0]    paren_nx;
   logic [2:0]    cont_nx;
   logic [3:0]    cont_type_nx;
   logic [7:0]    paren_up;
   logic [7:0]    paren_dn;
   logic          has_next;
   logic          out_free;
   logic [7:0]    c;
   logic [7:0]    nx;

   assign c        = cur_ff;
   assign nx       = rd_data_ff;
   assign paren_up = paren_ff + 8'd1;
   assign paren_dn = paren_ff - 8'd1;
   assign has_next = ({1'b0, scan_idx_ff} + (CW+1)'(1)) < {1'b0, byte_count_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.scan_done = (scan_idx_ff == byte_count_ff);
   assign status.out_free  = out_free;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

   // buffer write while loading, read address runs one ahead of the scan
   assign mem_wr = cmd.load && (byte_count_ff < CW'(MAX_LINE));

   always_comb begin
      if (cmd.prep0) begin
         rd_ptr = '0;
      end else if (cmd.prep1) begin
         rd_ptr = (CW+1)'(1);
      end else if (cmd.step) begin
         rd_ptr = {1'b0, scan_idx_ff} + (CW+1)'(2);
      end else begin
         rd_ptr = {1'b0, scan_idx_ff} + (CW+1)'(1);
      end
   end

   assign rd_addr = rd_ptr[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[byte_count_ff[AW-1:0]] <= req_data.char_byte;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   // per-byte scanner decision
   always_comb begin
      tok_type     = sot_pkg::TOK_TEXT;
      mode_nx      = mode_ff;
      paren_nx     = paren_ff;
      cont_nx      = CONT_NONE;
      cont_type_nx = cont_type_ff;
      if (cont_ff == CONT_ONE) begin
         tok_type = cont_type_ff;
      end else if (cont_ff == CONT_TPL) begin
         tok_type = sot_pkg::TOK_K_TEMPLATE;
         if (c != sot_pkg::CH_BANG) begin
            cont_nx = CONT_TPL;
         end
      end else if (cont_ff == CONT_KVAR && is_ident(c)) begin
         tok_type = sot_pkg::TOK_K_VAR;
         cont_nx  = CONT_KVAR;
      end else if (cont_ff == CONT_LOWER && is_lower(c)) begin
         tok_type = sot_pkg::TOK_TAG_NAME;
         cont_nx  = CONT_LOWER;
      end else if (karaoke_ff && c == sot_pkg::CH_BANG && bang_rem_ff >= CW'(2)) begin
         tok_type = sot_pkg::TOK_K_TEMPLATE;
         cont_nx  = CONT_TPL;
      end else if (karaoke_ff && c == sot_pkg::CH_DOLLAR && has_next && is_ident(nx)) begin
         tok_type = sot_pkg::TOK_K_VAR;
         cont_nx  = CONT_KVAR;
      end else begin
         unique case (mode_ff)
            MODE_TEXT: begin
               if (c == sot_pkg::CH_BACKSLASH && has_next &&
                   (nx == 8'h6E || nx == 8'h4E || nx == 8'h68)) begin
                  tok_type     = sot_pkg::TOK_LINEBREAK;
                  cont_nx      = CONT_ONE;
                  cont_type_nx = sot_pkg::TOK_LINEBREAK;
               end else if (c == sot_pkg::CH_LBRACE) begin
                  tok_type = sot_pkg::TOK_OVR_BEGIN;
                  paren_nx = 8'd0;
                  mode_nx  = MODE_OVR;
               end else begin
                  tok_type = sot_pkg::TOK_TEXT;
               end
            end
            MODE_OVR: begin
               if (c == sot_pkg::CH_LBRACE) begin
                  tok_type = sot_pkg::TOK_ERROR;
               end else if (c == sot_pkg::CH_RBRACE) begin
                  tok_type = sot_pkg::TOK_OVR_END;
                  mode_nx  = MODE_TEXT;
               end else if (c == sot_pkg::CH_BACKSLASH) begin
                  tok_type = sot_pkg::TOK_TAG_START;
                  mode_nx  = MODE_TAGSTART;
               end else if (is_blank(c)) begin
                  tok_type = sot_pkg::TOK_SPACE;
               end else begin
                  tok_type = sot_pkg::TOK_COMMENT;
               end
            end
            MODE_TAGSTART: begin
               if (is_blank(c)) begin
                  tok_type = sot_pkg::TOK_SPACE;
               end else if (c == 8'h72) begin
                  tok_type = sot_pkg::TOK_TAG_NAME;
                  mode_nx  = MODE_ARG;
               end else if (c == 8'h66 && has_next && nx == 8'h6E) begin
                  tok_type     = sot_pkg::TOK_TAG_NAME;
                  mode_nx      = MODE_ARG;
                  cont_nx      = CONT_ONE;
                  cont_type_nx = sot_pkg::TOK_TAG_NAME;
               end else if (c == sot_pkg::CH_BACKSLASH) begin
                  tok_type = sot_pkg::TOK_TAG_START;
               end else if (c == sot_pkg::CH_RBRACE) begin
                  tok_type = sot_pkg::TOK_OVR_END;
                  mode_nx  = MODE_TEXT;
               end else if (is_lower(c) || (c >= 8'h30 && c <= 8'h39)) begin
                  tok_type = sot_pkg::TOK_TAG_NAME;
                  mode_nx  = MODE_TAGNAME;
               end else begin
                  tok_type = sot_pkg::TOK_COMMENT;
                  mode_nx  = MODE_OVR;
               end
            end
            MODE_TAGNAME: begin
               if (is_lower(c)) begin
                  tok_type = sot_pkg::TOK_TAG_NAME;
                  mode_nx  = MODE_ARG;
                  cont_nx  = CONT_LOWER;
               end else if (c == sot_pkg::CH_LPAREN) begin
                  tok_type = sot_pkg::TOK_OPEN;
                  paren_nx = paren_up;
                  mode_nx  = MODE_ARG;
               end else if (c == sot_pkg::CH_RPAREN) begin
                  tok_type = sot_pkg::TOK_CLOSE;
                  paren_nx = paren_dn;
                  if (paren_dn == 8'd0) begin
                     mode_nx = MODE_OVR;
                  end
               end else if (c == sot_pkg::CH_RBRACE) begin
                  tok_type = sot_pkg::TOK_OVR_END;
                  mode_nx  = MODE_TEXT;
               end else if (c == sot_pkg::CH_BACKSLASH) begin
                  tok_type = sot_pkg::TOK_TAG_START;
                  mode_nx  = MODE_TAGSTART;
               end else begin
                  tok_type = sot_pkg::TOK_ARG;
                  mode_nx  = MODE_ARG;
               end
            end
            default: begin
               if (c == sot_pkg::CH_LBRACE) begin
                  tok_type = sot_pkg::TOK_ERROR;
               end else if (c == sot_pkg::CH_RBRACE) begin
                  tok_type = sot_pkg::TOK_OVR_END;
                  mode_nx  = MODE_TEXT;
               end else if (c == sot_pkg::CH_LPAREN) begin
                  tok_type = sot_pkg::TOK_OPEN;
                  paren_nx = paren_up;
               end else if (c == sot_pkg::CH_RPAREN) begin
                  tok_type = sot_pkg::TOK_CLOSE;
                  paren_nx = paren_dn;
                  // depth at or below zero closes the argument list
                  if (paren_dn == 8'd0 || paren_dn[7]) begin
                     paren_nx = 8'd0;
                     mode_nx  = MODE_OVR;
                  end
               end else if (c == sot_pkg::CH_BACKSLASH) begin
                  tok_type = sot_pkg::TOK_TAG_START;
                  mode_nx  = MODE_TAGSTART;
               end else if (c == sot_pkg::CH_COMMA) begin
                  tok_type = sot_pkg::TOK_ARG_SEP;
               end else if (is_blank(c)) begin
                  tok_type = sot_pkg::TOK_SPACE;
               end else begin
                  tok_type = sot_pkg::TOK_ARG;
               end
            end
         endcase
      end
   end

   // next-state for load, scan, merge and output
   always_comb begin
      karaoke_in    = karaoke_ff;
      byte_count_in = byte_count_ff;
      bang_count_in = bang_count_ff;
      bang_rem_in   = bang_rem_ff;
      overflow_in   = overflow_ff;
      scan_idx_in   = scan_idx_ff;
      mode_in       = mode_ff;
      paren_in      = paren_ff;
      cont_in       = cont_ff;
      run_valid_in  = run_valid_ff;
      tok_count_in  = tok_count_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cur_in        = cur_ff;
      cont_type_in  = cont_type_ff;
      run_type_in   = run_type_ff;
      run_len_in    = run_len_ff;
      hold_type_in  = hold_type_ff;
      hold_len_in   = hold_len_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_wr_en) begin
         karaoke_in = csr_wr_data;
      end

      // collect bytes, count template marks, flag dropped bytes
      if (cmd.load) begin
         if (mem_wr) begin
            byte_count_in = byte_count_ff + CW'(1);
            if (req_data.char_byte == sot_pkg::CH_BANG) begin
               bang_count_in = bang_count_ff + CW'(1);
            end
         end else begin
            overflow_in = 1'b1;
         end
      end

      if (cmd.prep0) begin
         bang_rem_in   = bang_count_ff;
         scan_idx_in   = '0;
         mode_in       = MODE_TEXT;
         paren_in      = 8'd0;
         cont_in       = CONT_NONE;
         run_valid_in  = 1'b0;
         tok_count_in  = '0;
         hold_valid_in = 1'b0;
      end

      if (cmd.prep1) begin
         cur_in = rd_data_ff;
      end

      // one byte per step, merged into the pending run
      if (cmd.step) begin
         cur_in       = rd_data_ff;
         scan_idx_in  = scan_idx_ff + CW'(1);
         mode_in      = mode_nx;
         paren_in     = paren_nx;
         cont_in      = cont_nx;
         cont_type_in = cont_type_nx;
         if (c == sot_pkg::CH_BANG && bang_rem_ff != '0) begin
            bang_rem_in = bang_rem_ff - CW'(1);
         end
         if (run_valid_ff && run_type_ff == tok_type) begin
            run_len_in = run_len_ff + 7'd1;
         end else begin
            run_valid_in = 1'b1;
            run_type_in  = tok_type;
            run_len_in   = 7'd1;
            if (run_valid_ff) begin
               // the token at the cap waits so it can carry the last mark
               if (tok_count_ff < TOK_CNT_W_L'(sot_pkg::TOKEN_CAP - 1)) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.token_type   = run_type_ff;
                  rsp_data_in.token_length = run_len_ff;
                  rsp_data_in.last_token   = 1'b0;
                  rsp_data_in.overflow     = overflow_ff;
                  tok_count_in             = tok_count_ff + TOK_CNT_W_L'(1);
               end else if (!hold_valid_ff) begin
                  hold_valid_in = 1'b1;
                  hold_type_in  = run_type_ff;
                  hold_len_in   = run_len_ff;
               end
            end
         end
      end

      // final token of the line, then clear per-line state
      if (cmd.finish) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.token_type   = hold_valid_ff ? hold_type_ff : run_type_ff;
         rsp_data_in.token_length = hold_valid_ff ? hold_len_ff : run_len_ff;
         rsp_data_in.last_token   = 1'b1;
         rsp_data_in.overflow     = overflow_ff;
         byte_count_in            = '0;
         bang_count_in            = '0;
         bang_rem_in              = '0;
         overflow_in              = 1'b0;
         scan_idx_in              = '0;
         mode_in                  = MODE_TEXT;
         paren_in                 = 8'd0;
         cont_in                  = CONT_NONE;
         run_valid_in             = 1'b0;
         hold_valid_in            = 1'b0;
         tok_count_in             = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         karaoke_ff    <= 1'b0;
         byte_count_ff <= '0;
         bang_count_ff <= '0;
         bang_rem_ff   <= '0;
         overflow_ff   <= 1'b0;
         scan_idx_ff   <= '0;
         mode_ff       <= MODE_TEXT;
         paren_ff      <= 8'd0;
         cont_ff       <= CONT_NONE;
         run_valid_ff  <= 1'b0;
         tok_count_ff  <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         karaoke_ff    <= karaoke_in;
         byte_count_ff <= byte_count_in;
         bang_count_ff <= bang_count_in;
         bang_rem_ff   <= bang_rem_in;
         overflow_ff   <= overflow_in;
         scan_idx_ff   <= scan_idx_in;
         mode_ff       <= mode_in;
         paren_ff      <= paren_in;
         cont_ff       <= cont_in;
         run_valid_ff  <= run_valid_in;
         tok_count_ff  <= tok_count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cont_type_ff <= cont_type_in;
      run_type_ff  <= run_type_in;
      run_len_ff   <= run_len_in;
      hold_type_ff <= hold_type_in;
      hold_len_ff  <= hold_len_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

@@ rtl/subtitle_override_tokenizer_core.sv @@
// a line of n transfers is loaded, then states PREP0 and PREP1 prime the buffer read,
// SCAN walks the m stored bytes (at most MAX_LINE) to their end, FINAL sends the last token
// the scan takes one byte per cycle while results are not stalled; input is stalled from
// the last byte until the final token is queued, so a new line waits for the last one;
// a stalled result pauses the scan
// reset is synchronous, active high: clears control state and karaoke_enable, buffer undefined
module subtitle_override_tokenizer_core #(
   parameter int MAX_LINE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sot_pkg::req_payload_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sot_pkg::rsp_payload_type  rsp_data
);

   sot_pkg::cmd_type    cmd;
   sot_pkg::status_type status;

   // sequencer
   sot_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_byte),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // line buffer, scanner and token merge
   sot_datapath #(
      .MAX_LINE (MAX_LINE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

import sot_pkg::*;

// token predictor and in-order checker for the tokenizer results
class token_scoreboard #(int LINE_CAP = 64);

   typedef enum logic [2:0] {
      PLAIN,
      IN_OVERRIDE,
      AT_TAG,
      IN_TAG_NAME,
      IN_ARGS
   } scan_mode_type;

   rsp_payload_type expected_tokens[$];
   int              error_count;

   // line being collected
   logic [7:0] line_bytes[LINE_CAP];
   int         line_len;
   bit         line_overflow;
   bit         karaoke_on;

   // pending merged token
   bit              run_open;
   logic [3:0]      run_kind;
   int              run_len;
   rsp_payload_type line_tokens[$];

   function new();
      error_count = 0;
      line_len = 0;
      line_overflow = 0;
      karaoke_on = 0;
      run_open = 0;
   endfunction

   function void set_karaoke(bit on);
      karaoke_on = on;
   endfunction

   function bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function bit is_lower(logic [7:0] c);
      return c >= "a" && c <= "z";
   endfunction

   function bit is_ident(logic [7:0] c);
      return is_lower(c) || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function int blank_span(int from);
      int j;
      j = from;
      while (j < line_len && is_blank(line_bytes[j])) j++;
      return j - from;
   endfunction

   // close the pending token into this line's list
   function void close_run();
      rsp_payload_type tok;
      if (run_open && line_tokens.size() < TOKEN_CAP) begin
         tok.token_type   = run_kind;
         tok.token_length = 7'(run_len);
         tok.last_token   = 1'b0;
         tok.overflow     = line_overflow;
         line_tokens = {line_tokens, tok};
      end
      run_open = 0;
      run_len = 0;
   endfunction

   // merge with the pending token when the kind matches
   function void add_span(logic [3:0] kind, int len);
      if (len == 0) return;
      if (run_open && run_kind == kind) begin
         run_len += len;
      end else begin
         close_run();
         run_open = 1;
         run_kind = kind;
         run_len = len;
      end
   endfunction

   // walk the stored line and queue the tokens it yields
   function void tokenize_line();
      int              n, i, j, span;
      logic [7:0]      c, nx;
      bit              has_nx;
      scan_mode_type   mode;
      logic [7:0]      depth;
      rsp_payload_type tok;
      n = line_len;
      i = 0;
      mode = PLAIN;
      depth = 8'd0;
      run_open = 0;
      run_len = 0;
      line_tokens.delete();
      while (i < n) begin
         c = line_bytes[i];
         has_nx = (i + 1 < n);
         nx = has_nx ? line_bytes[i + 1] : 8'd0;

         // karaoke template needs a later bang to close it
         if (karaoke_on && c == CH_BANG) begin
            j = i + 1;
            while (j < n && line_bytes[j] != CH_BANG) j++;
            if (j < n) begin
               add_span(TOK_K_TEMPLATE, j - i + 1);
               i = j + 1;
               continue;
            end
         end
         // karaoke variable
         if (karaoke_on && c == CH_DOLLAR && has_nx && is_ident(nx)) begin
            j = i + 1;
            while (j < n && is_ident(line_bytes[j])) j++;
            add_span(TOK_K_VAR, j - i);
            i = j;
            continue;
         end

         span = 1;
         case (mode)
            PLAIN: begin
               if (c == CH_BACKSLASH && has_nx && (nx == "n" || nx == "N" || nx == "h")) begin
                  add_span(TOK_LINEBREAK, 2);
                  span = 2;
               end else if (c == CH_LBRACE) begin
                  add_span(TOK_OVR_BEGIN, 1);
                  depth = 8'd0;
                  mode = IN_OVERRIDE;
               end else begin
                  add_span(TOK_TEXT, 1);
               end
            end
            IN_OVERRIDE: begin
               if (c == CH_LBRACE) begin
                  add_span(TOK_ERROR, 1);
               end else if (c == CH_RBRACE) begin
                  add_span(TOK_OVR_END, 1);
                  mode = PLAIN;
               end else if (c == CH_BACKSLASH) begin
                  add_span(TOK_TAG_START, 1);
                  mode = AT_TAG;
               end else if (is_blank(c)) begin
                  span = blank_span(i);
                  add_span(TOK_SPACE, span);
               end else begin
                  add_span(TOK_COMMENT, 1);
               end
            end
            AT_TAG: begin
               if (is_blank(c)) begin
                  span = blank_span(i);
                  add_span(TOK_SPACE, span);
               end else if (c == "r") begin
                  add_span(TOK_TAG_NAME, 1);
                  mode = IN_ARGS;
               end else if (c == "f" && has_nx && nx == "n") begin
                  add_span(TOK_TAG_NAME, 2);
                  span = 2;
                  mode = IN_ARGS;
               end else if (c == CH_BACKSLASH) begin
                  add_span(TOK_TAG_START, 1);
               end else if (c == CH_RBRACE) begin
                  add_span(TOK_OVR_END, 1);
                  mode = PLAIN;
               end else if (is_lower(c) || (c >= "0" && c <= "9")) begin
                  add_span(TOK_TAG_NAME, 1);
                  mode = IN_TAG_NAME;
               end else begin
                  add_span(TOK_COMMENT, 1);
                  mode = IN_OVERRIDE;
               end
            end
            IN_TAG_NAME: begin
               if (is_lower(c)) begin
                  j = i;
                  while (j < n && is_lower(line_bytes[j])) j++;
                  span = j - i;
                  add_span(TOK_TAG_NAME, span);
                  mode = IN_ARGS;
               end else if (c == CH_LPAREN) begin
                  add_span(TOK_OPEN, 1);
                  depth = depth + 8'd1;
                  mode = IN_ARGS;
               end else if (c == CH_RPAREN) begin
                  // only an exact return to zero leaves the tag
                  add_span(TOK_CLOSE, 1);
                  depth = depth - 8'd1;
                  if (depth == 8'd0) mode = IN_OVERRIDE;
               end else if (c == CH_RBRACE) begin
                  add_span(TOK_OVR_END, 1);
                  mode = PLAIN;
               end else if (c == CH_BACKSLASH) begin
                  add_span(TOK_TAG_START, 1);
                  mode = AT_TAG;
               end else begin
                  add_span(TOK_ARG, 1);
                  mode = IN_ARGS;
               end
            end
            default: begin
               if (c == CH_LBRACE) begin
                  add_span(TOK_ERROR, 1);
               end else if (c == CH_RBRACE) begin
                  add_span(TOK_OVR_END, 1);
                  mode = PLAIN;
               end else if (c == CH_LPAREN) begin
                  add_span(TOK_OPEN, 1);
                  depth = depth + 8'd1;
               end else if (c == CH_RPAREN) begin
                  // zero or negative depth ends the argument list
                  add_span(TOK_CLOSE, 1);
                  depth = depth - 8'd1;
                  if (depth == 8'd0 || depth[7]) begin
                     depth = 8'd0;
                     mode = IN_OVERRIDE;
                  end
               end else if (c == CH_BACKSLASH) begin
                  add_span(TOK_TAG_START, 1);
                  mode = AT_TAG;
               end else if (c == CH_COMMA) begin
                  add_span(TOK_ARG_SEP, 1);
               end else if (is_blank(c)) begin
                  span = blank_span(i);
                  add_span(TOK_SPACE, span);
               end else begin
                  add_span(TOK_ARG, 1);
               end
            end
         endcase
         i += span;
      end
      close_run();

      // final token of the line carries the last flag
      foreach (line_tokens[k]) begin
         tok = line_tokens[k];
         tok.last_token = (k == line_tokens.size() - 1);
         expected_tokens = {expected_tokens, tok};
      end
   endfunction

   // accepted input transfer
   function void note_byte(logic [7:0] c, bit last);
      if (line_len < LINE_CAP) begin
         line_bytes[line_len] = c;
         line_len++;
      end else begin
         line_overflow = 1;
      end
      if (last) begin
         tokenize_line();
         line_len = 0;
         line_overflow = 0;
      end
   endfunction

   function void compare_field(string name, logic [6:0] want, logic [6:0] seen);
      if (seen !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
         error_count++;
      end
   endfunction

   // accepted result transfer
   function void check_token(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_tokens.size() == 0) begin
         $display("%0t: token with nothing expected, type %0d length %0d",
                  $time, got.token_type, got.token_length);
         error_count++;
         return;
      end
      want = expected_tokens.pop_front();
      compare_field("token_type", 7'(want.token_type), 7'(got.token_type));
      compare_field("token_length", want.token_length, got.token_length);
      compare_field("last_token", 7'(want.last_token), 7'(got.last_token));
      compare_field("overflow", 7'(want.overflow), 7'(got.overflow));
   endfunction

endclass

module tb;

   localparam int LINE_CAP    = 64;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 8;
   localparam int PHASE_BYTES = 85;

   logic            clock;
   logic            reset;
   logic            csr_wr_en;
   logic            csr_wr_data;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;

   token_scoreboard #(LINE_CAP) sb;

   logic [7:0] build_q[$];
   bit         send_quiet;
   bit         rsp_quiet;
   int         hold_requests;

   subtitle_override_tokenizer_core #(
      .MAX_LINE(LINE_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // mostly no gap, some short gaps, a few long ones
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side: check each transfer, then choose the next stall
   int stall_left = 0;
   int hold_served = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_token(rsp_data);
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         stall_left = HOLD_CYCLES;
      end else if (stall_left == 0) begin
         stall_left = pick_gap(rsp_quiet);
      end
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
   end

   // line builders
   function automatic void put_str(string s);
      foreach (s[k]) build_q = {build_q, s[k]};
   endfunction

   function automatic void put_word();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0:       build_q = {build_q, 8'("A" + $urandom_range(0, 25))};
            1:       build_q = {build_q, 8'("_")};
            default: build_q = {build_q, 8'("a" + $urandom_range(0, 25))};
         endcase
      end
   endfunction

   function automatic void put_number();
      put_str($sformatf("%0d", $urandom_range(0, 999)));
   endfunction

   function automatic void put_tag();
      put_str("\\");
      case ($urandom_range(0, 8))
         0: put_str("b1");
         1: begin
            put_str("fn");
            put_word();
         end
         2: put_str("r");
         3: begin
            put_str("pos(");
            put_number();
            put_str(",");
            put_number();
            put_str(")");
         end
         4: begin
            put_str("t(\\frz");
            put_number();
            put_str(")");
         end
         5: put_str("3c&HFF&");
         6: begin
            put_str("clip((");
            put_number();
            put_str(") ");
         end
         7: put_str("fscx");
         default: put_word();
      endcase
   endfunction

   function automatic void make_line(int target);
      string specials;
      specials = "{}\\(),!$ \t";
      build_q.delete();
      while (build_q.size() < target) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: put_word();
            5: begin
               if ($urandom_range(0, 1) != 0) put_str(" ");
               else put_str("\t ");
            end
            6, 7: begin
               case ($urandom_range(0, 3))
                  0:       put_str("\\n");
                  1:       put_str("\\h");
                  default: put_str("\\N");
               endcase
            end
            8, 9, 10, 11, 12: begin
               // override block, sometimes left open
               put_str("{");
               repeat ($urandom_range(1, 3)) put_tag();
               if ($urandom_range(0, 9) != 0) put_str("}");
            end
            13: begin
               put_str("!");
               put_word();
               put_str("!");
            end
            14: begin
               put_str("$");
               put_word();
            end
            15, 16: build_q = {build_q, specials[$urandom_range(0, specials.len() - 1)]};
            default: build_q = {build_q, 8'($urandom_range(0, 255))};
         endcase
      end
      while (build_q.size() > target) void'(build_q.pop_back());
   endfunction

   // one input transfer, then an optional gap
   task automatic send_byte(logic [7:0] c, bit last);
      int gap;
      req_valid <= 1'b1;
      req_data <= '{char_byte: c, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(c, last);
      gap = pick_gap(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_built();
      foreach (build_q[k]) send_byte(build_q[k], k == build_q.size() - 1);
   endtask

   task automatic send_text(string s);
      build_q.delete();
      put_str(s);
      send_built();
   endtask

   // wait until every predicted token has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_karaoke(bit on);
      csr_wr_en <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_karaoke(on);
   endtask

   task automatic run_phase(bit karaoke, bit quiet, bit squeeze);
      int sent;
      int r;
      drain();
      write_karaoke(karaoke);
      send_quiet = quiet;
      rsp_quiet = quiet;
      // receiver holds off while full lines keep coming
      if (squeeze) hold_requests++;
      // first line always runs past the buffer
      make_line($urandom_range(LINE_CAP + 2, LINE_CAP + 26));
      sent = build_q.size();
      send_built();
      while (sent < PHASE_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 80) make_line($urandom_range(1, 20));
         else if (r < 95) make_line($urandom_range(21, LINE_CAP));
         else make_line($urandom_range(LINE_CAP + 1, LINE_CAP + 16));
         sent += build_q.size();
         send_built();
      end
   endtask

   initial begin
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      send_quiet = 1'b0;
      rsp_quiet = 1'b0;
      hold_requests = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed lines, karaoke off
      write_karaoke(1'b0);
      send_text("\\N{\\fs(1, 2)}");
      build_q.delete();
      build_q = {build_q, 8'h00};
      build_q = {build_q, 8'hFF};
      send_built();

      // directed line, karaoke on: template, variable, error, unclosed bang
      drain();
      write_karaoke(1'b1);
      send_text("!a!$v{{!\\r}");

      // random phases
      run_phase(1'b0, 1'b0, 1'b0);
      run_phase(1'b1, 1'b0, 1'b1);
      run_phase(1'b0, 1'b1, 1'b0);
      run_phase(1'b1, 1'b0, 1'b0);

      drain();
      if (sb.error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
